// File: rtl/core/hsvc_pkg.sv
package hsvc_pkg;

   localparam int unsigned TURN_DEG     = 360;
   localparam int unsigned SECTOR_DEG   = 60;
   localparam int unsigned SECTOR_SHIFT = 2;
   localparam int unsigned SECTOR_ODD   = SECTOR_DEG >> SECTOR_SHIFT;

   typedef logic [2:0] sector_type;

   localparam sector_type SECT_RY = 3'd0;
   localparam sector_type SECT_YG = 3'd1;
   localparam sector_type SECT_GC = 3'd2;
   localparam sector_type SECT_CB = 3'd3;
   localparam sector_type SECT_BM = 3'd4;
   localparam sector_type SECT_MR = 3'd5;

endpackage

// File: rtl/core/hsvc_scale.sv
module hsvc_scale #(
   parameter int CHANNEL_BITS  = 8,
   parameter int HUE_FRAC_BITS = 6,
   localparam longint unsigned CH_MAX  = (longint'(1) << CHANNEL_BITS) - 1,
   localparam longint unsigned SECTOR  = longint'(hsvc_pkg::SECTOR_DEG) << HUE_FRAC_BITS,
   localparam longint unsigned FULL    = CH_MAX * SECTOR,
   localparam int              X_BITS  = $clog2(FULL + 1)
) (
   input  logic                    clock,
   input  logic [CHANNEL_BITS-1:0] in_value,
   input  logic [X_BITS-1:0]       in_term,
   output logic [CHANNEL_BITS-1:0] out_level
);

   localparam int              N_BITS    = CHANNEL_BITS + X_BITS;
   localparam int              PRE_SHIFT = HUE_FRAC_BITS + hsvc_pkg::SECTOR_SHIFT;
   localparam int              N2_BITS   = N_BITS - PRE_SHIFT;
   localparam longint unsigned DIVISOR   = longint'(hsvc_pkg::SECTOR_ODD) * CH_MAX;
   localparam longint unsigned RECIP     = (longint'(1) << N2_BITS) / DIVISOR;
   localparam int              RECIP_BITS = $clog2(RECIP + 1);
   localparam int              PROD_BITS = N2_BITS + RECIP_BITS;

   logic [N_BITS-1:0]       num_full;
   logic [PROD_BITS-1:0]    est_prod;
   logic [N2_BITS-1:0]      diff;

   logic [N2_BITS-1:0]      st1_num_in, st1_num_ff;
   logic [CHANNEL_BITS-1:0] st2_est_in, st2_est_ff;
   logic [N2_BITS-1:0]      st2_num_ff;
   logic [N2_BITS-1:0]      st3_back_in, st3_back_ff;
   logic [CHANNEL_BITS-1:0] st3_est_ff;
   logic [N2_BITS-1:0]      st3_num_ff;
   logic [CHANNEL_BITS-1:0] st4_level_in, st4_level_ff;

   always_comb begin
      num_full     = N_BITS'(in_value) * N_BITS'(in_term);
      st1_num_in   = N2_BITS'(num_full >> PRE_SHIFT);
      est_prod     = PROD_BITS'(st1_num_ff) * PROD_BITS'(RECIP);
      st2_est_in   = CHANNEL_BITS'(est_prod >> N2_BITS);
      st3_back_in  = N2_BITS'(N2_BITS'(st2_est_ff) * N2_BITS'(DIVISOR));
      diff         = st3_num_ff - st3_back_ff;
      st4_level_in = st3_est_ff + CHANNEL_BITS'(diff >= N2_BITS'(DIVISOR));
   end

   always_ff @(posedge clock) begin
      st1_num_ff   <= st1_num_in;
      st2_est_ff   <= st2_est_in;
      st2_num_ff   <= st1_num_ff;
      st3_back_ff  <= st3_back_in;
      st3_est_ff   <= st2_est_ff;
      st3_num_ff   <= st2_num_ff;
      st4_level_ff <= st4_level_in;
   end

   assign out_level = st4_level_ff;

endmodule

// File: rtl/core/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter.
// Input channel: a pixel (req_hue, req_saturation, req_brightness) is taken at each
// rising edge where start is high and busy is low. Hue counts 1/2^HUE_FRAC_BITS
// degree; a hue of a full turn or more reads as zero. Saturation and brightness
// are CHANNEL_BITS-bit fractions where all ones means 1.0.
// Result channel: rsp_valid is high for exactly one cycle with rsp_red,
// rsp_green and rsp_blue once the pixel has passed the pipeline. Results leave
// in the order the pixels came in, one result per pixel.
// Throughput: one pixel per clock whenever busy is low. The pipeline runs
// through hue split, term build, term multiply, reciprocal divide estimate,
// back multiply and one-step correction.
// busy is high only during reset; the pipeline itself never stalls.
// Reset: synchronous, active high; clears every valid bit, so no beat that was
// in flight at reset appears on the result channel.
// The receiver has no way to hold results off; each beat must be taken when shown.
module hsv_to_rgb_converter #(
   parameter int CHANNEL_BITS  = 8,
   parameter int HUE_FRAC_BITS = 6,
   localparam int HUE_BITS = $clog2(longint'(hsvc_pkg::TURN_DEG) << HUE_FRAC_BITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [HUE_BITS-1:0]     req_hue,
   input  logic [CHANNEL_BITS-1:0] req_saturation,
   input  logic [CHANNEL_BITS-1:0] req_brightness,
   output logic                    rsp_valid,
   output logic [CHANNEL_BITS-1:0] rsp_red,
   output logic [CHANNEL_BITS-1:0] rsp_green,
   output logic [CHANNEL_BITS-1:0] rsp_blue
);

   localparam longint unsigned CH_MAX   = (longint'(1) << CHANNEL_BITS) - 1;
   localparam longint unsigned SECTOR   = longint'(hsvc_pkg::SECTOR_DEG) << HUE_FRAC_BITS;
   localparam longint unsigned FULL     = CH_MAX * SECTOR;
   localparam int              X_BITS   = $clog2(FULL + 1);
   localparam int              DEG_BITS = HUE_BITS - HUE_FRAC_BITS;
   localparam int              REM_DEG_BITS = $clog2(hsvc_pkg::SECTOR_DEG);
   localparam int              REM_BITS = REM_DEG_BITS + HUE_FRAC_BITS;
   localparam int              DEPTH    = 4;
   localparam logic [REM_BITS-1:0] LO_MASK = REM_BITS'((longint'(1) << HUE_FRAC_BITS) - 1);
   localparam logic [DEG_BITS-1:0] DEG_60  = DEG_BITS'(hsvc_pkg::SECTOR_DEG);
   localparam logic [DEG_BITS-1:0] DEG_120 = DEG_BITS'(2 * hsvc_pkg::SECTOR_DEG);
   localparam logic [DEG_BITS-1:0] DEG_180 = DEG_BITS'(3 * hsvc_pkg::SECTOR_DEG);
   localparam logic [DEG_BITS-1:0] DEG_240 = DEG_BITS'(4 * hsvc_pkg::SECTOR_DEG);
   localparam logic [DEG_BITS-1:0] DEG_300 = DEG_BITS'(5 * hsvc_pkg::SECTOR_DEG);
   localparam logic [DEG_BITS-1:0] DEG_360 = DEG_BITS'(hsvc_pkg::TURN_DEG);

   logic                     accept;
   logic [DEG_BITS-1:0]      hue_deg;
   logic [DEG_BITS-1:0]      sector_base;
   logic [REM_BITS-1:0]      hue_lo;
   logic [REM_DEG_BITS-1:0]  rem_deg;

   logic                     s1_valid_ff;
   hsvc_pkg::sector_type     s1_sector_in, s1_sector_ff;
   logic [REM_BITS-1:0]      s1_rem_in, s1_rem_ff;
   logic [CHANNEL_BITS-1:0]  s1_sat_ff, s1_val_ff;

   logic                     s2_valid_ff;
   hsvc_pkg::sector_type     s2_sector_ff;
   logic [X_BITS-1:0]        s2_prod_in, s2_prod_ff;
   logic [X_BITS-1:0]        s2_pterm_in, s2_pterm_ff;
   logic [CHANNEL_BITS-1:0]  s2_val_ff;

   logic                     s3_valid_ff;
   hsvc_pkg::sector_type     s3_sector_ff;
   logic [X_BITS-1:0]        s3_pterm_ff;
   logic [X_BITS-1:0]        s3_qterm_in, s3_qterm_ff;
   logic [X_BITS-1:0]        s3_tterm_in, s3_tterm_ff;
   logic [CHANNEL_BITS-1:0]  s3_val_ff;

   logic [DEPTH-1:0]         valid_pipe_ff;
   hsvc_pkg::sector_type     sector_pipe_ff [DEPTH];
   logic [CHANNEL_BITS-1:0]  value_pipe_ff  [DEPTH];

   logic [CHANNEL_BITS-1:0]  level_p, level_q, level_t;
   logic [CHANNEL_BITS-1:0]  red_in, green_in, blue_in;
   logic                     rsp_valid_ff;
   logic [CHANNEL_BITS-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // split hue into sector and in-sector remainder
   always_comb begin
      hue_deg = DEG_BITS'(req_hue >> HUE_FRAC_BITS);
      hue_lo  = REM_BITS'(req_hue) & LO_MASK;
      if (hue_deg >= DEG_360) begin
         hue_deg = '0;
         hue_lo  = '0;
      end
      if (hue_deg >= DEG_300) begin
         s1_sector_in = hsvc_pkg::SECT_MR;
         sector_base  = DEG_300;
      end else if (hue_deg >= DEG_240) begin
         s1_sector_in = hsvc_pkg::SECT_BM;
         sector_base  = DEG_240;
      end else if (hue_deg >= DEG_180) begin
         s1_sector_in = hsvc_pkg::SECT_CB;
         sector_base  = DEG_180;
      end else if (hue_deg >= DEG_120) begin
         s1_sector_in = hsvc_pkg::SECT_GC;
         sector_base  = DEG_120;
      end else if (hue_deg >= DEG_60) begin
         s1_sector_in = hsvc_pkg::SECT_YG;
         sector_base  = DEG_60;
      end else begin
         s1_sector_in = hsvc_pkg::SECT_RY;
         sector_base  = '0;
      end
      rem_deg   = REM_DEG_BITS'(hue_deg - sector_base);
      s1_rem_in = (REM_BITS'(rem_deg) << HUE_FRAC_BITS) | hue_lo;
   end

   // numerators over M*D: p = (M-S)*D, q = M*D - S*rem, t = (M-S)*D + S*rem
   always_comb begin
      s2_prod_in  = X_BITS'(s1_sat_ff) * X_BITS'(s1_rem_ff);
      s2_pterm_in = X_BITS'(X_BITS'(X_BITS'(CH_MAX) - X_BITS'(s1_sat_ff)) * X_BITS'(SECTOR));
      s3_qterm_in = X_BITS'(FULL) - s2_prod_ff;
      s3_tterm_in = s2_pterm_ff + s2_prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         valid_pipe_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         valid_pipe_ff <= {valid_pipe_ff[DEPTH-2:0], s3_valid_ff};
         rsp_valid_ff  <= valid_pipe_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= s1_sector_in;
      s1_rem_ff    <= s1_rem_in;
      s1_sat_ff    <= req_saturation;
      s1_val_ff    <= req_brightness;
      s2_sector_ff <= s1_sector_ff;
      s2_prod_ff   <= s2_prod_in;
      s2_pterm_ff  <= s2_pterm_in;
      s2_val_ff    <= s1_val_ff;
      s3_sector_ff <= s2_sector_ff;
      s3_pterm_ff  <= s2_pterm_ff;
      s3_qterm_ff  <= s3_qterm_in;
      s3_tterm_ff  <= s3_tterm_in;
      s3_val_ff    <= s2_val_ff;
      sector_pipe_ff[0] <= s3_sector_ff;
      value_pipe_ff[0]  <= s3_val_ff;
      for (int i = 1; i < DEPTH; i++) begin
         sector_pipe_ff[i] <= sector_pipe_ff[i-1];
         value_pipe_ff[i]  <= value_pipe_ff[i-1];
      end
      rsp_red_ff   <= red_in;
      rsp_green_ff <= green_in;
      rsp_blue_ff  <= blue_in;
   end

   hsvc_scale #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_scale_p (
      .clock     (clock),
      .in_value  (s3_val_ff),
      .in_term   (s3_pterm_ff),
      .out_level (level_p)
   );

   hsvc_scale #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_scale_q (
      .clock     (clock),
      .in_value  (s3_val_ff),
      .in_term   (s3_qterm_ff),
      .out_level (level_q)
   );

   hsvc_scale #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_scale_t (
      .clock     (clock),
      .in_value  (s3_val_ff),
      .in_term   (s3_tterm_ff),
      .out_level (level_t)
   );

   // route terms to channels by sector
   always_comb begin
      unique case (sector_pipe_ff[DEPTH-1])
         hsvc_pkg::SECT_RY: begin
            red_in   = value_pipe_ff[DEPTH-1];
            green_in = level_t;
            blue_in  = level_p;
         end
         hsvc_pkg::SECT_YG: begin
            red_in   = level_q;
            green_in = value_pipe_ff[DEPTH-1];
            blue_in  = level_p;
         end
         hsvc_pkg::SECT_GC: begin
            red_in   = level_p;
            green_in = value_pipe_ff[DEPTH-1];
            blue_in  = level_t;
         end
         hsvc_pkg::SECT_CB: begin
            red_in   = level_p;
            green_in = level_q;
            blue_in  = value_pipe_ff[DEPTH-1];
         end
         hsvc_pkg::SECT_BM: begin
            red_in   = level_t;
            green_in = level_p;
            blue_in  = value_pipe_ff[DEPTH-1];
         end
         default: begin
            red_in   = value_pipe_ff[DEPTH-1];
            green_in = level_p;
            blue_in  = level_q;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

   a_beat_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 rsp_valid)
      else $error("accepted beat did not show up after eight cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##8 !rsp_valid)
      else $error("result beat without an accepted pixel");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_saturation == '0) |-> ##8
      (rsp_red == $past(req_brightness, 8) && rsp_green == $past(req_brightness, 8)
       && rsp_blue == $past(req_brightness, 8)))
      else $error("zero saturation did not give grey at brightness");

   a_value_channel: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8
      (rsp_red == $past(req_brightness, 8) || rsp_green == $past(req_brightness, 8)
       || rsp_blue == $past(req_brightness, 8)))
      else $error("no channel carries the brightness");

endmodule

// File: sim/hsv_color_checker.sv
module hsv_color_checker #(
   parameter int CHANNEL_BITS  = 8,
   parameter int HUE_FRAC_BITS = 6,
   parameter int HUE_BITS      = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [HUE_BITS-1:0]     req_hue,
   input  logic [CHANNEL_BITS-1:0] req_saturation,
   input  logic [CHANNEL_BITS-1:0] req_brightness,
   input  logic                    rsp_valid,
   input  logic [CHANNEL_BITS-1:0] rsp_red,
   input  logic [CHANNEL_BITS-1:0] rsp_green,
   input  logic [CHANNEL_BITS-1:0] rsp_blue,
   output int                      fail_count,
   output int                      expected_left
);

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rgb_pixel_type;

   rgb_pixel_type expected_pixels[$];
   int            reported;

   function automatic rgb_pixel_type convert_pixel(input logic [HUE_BITS-1:0] hue,
                                                    input logic [CHANNEL_BITS-1:0] sat,
                                                    input logic [CHANNEL_BITS-1:0] val);
      longint unsigned      full, span, turn, md, h, s, v, rem, p, q, t;
      hsvc_pkg::sector_type sect;
      rgb_pixel_type        px;
      full = (64'd1 << CHANNEL_BITS) - 1;
      span = 64'(hsvc_pkg::SECTOR_DEG) << HUE_FRAC_BITS;
      turn = 64'(hsvc_pkg::TURN_DEG) << HUE_FRAC_BITS;
      md   = full * span;
      h    = 64'(hue);
      s    = 64'(sat);
      v    = 64'(val);
      if (s == 0) begin
         px.red   = CHANNEL_BITS'(v);
         px.green = CHANNEL_BITS'(v);
         px.blue  = CHANNEL_BITS'(v);
         return px;
      end
      if (h >= turn)
         h = 0;
      sect = hsvc_pkg::sector_type'(h / span);
      rem  = h % span;
      p    = (v * (full - s)) / full;
      q    = (v * (md - s * rem)) / md;
      t    = (v * (md - s * (span - rem))) / md;
      case (sect)
         hsvc_pkg::SECT_RY: begin
            px.red = CHANNEL_BITS'(v); px.green = CHANNEL_BITS'(t); px.blue = CHANNEL_BITS'(p);
         end
         hsvc_pkg::SECT_YG: begin
            px.red = CHANNEL_BITS'(q); px.green = CHANNEL_BITS'(v); px.blue = CHANNEL_BITS'(p);
         end
         hsvc_pkg::SECT_GC: begin
            px.red = CHANNEL_BITS'(p); px.green = CHANNEL_BITS'(v); px.blue = CHANNEL_BITS'(t);
         end
         hsvc_pkg::SECT_CB: begin
            px.red = CHANNEL_BITS'(p); px.green = CHANNEL_BITS'(q); px.blue = CHANNEL_BITS'(v);
         end
         hsvc_pkg::SECT_BM: begin
            px.red = CHANNEL_BITS'(t); px.green = CHANNEL_BITS'(p); px.blue = CHANNEL_BITS'(v);
         end
         default: begin
            px.red = CHANNEL_BITS'(v); px.green = CHANNEL_BITS'(p); px.blue = CHANNEL_BITS'(q);
         end
      endcase
      return px;
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type got;
      rgb_pixel_type want;
      if (reset) begin
         expected_pixels.delete();
         reported      = 0;
         fail_count    <= 0;
         expected_left <= 0;
      end else begin
         if (start && !busy)
            expected_pixels.push_back(convert_pixel(req_hue, req_saturation, req_brightness));
         if (rsp_valid) begin
            got.red   = rsp_red;
            got.green = rsp_green;
            got.blue  = rsp_blue;
            if (expected_pixels.size() == 0) begin
               if (reported < 10)
                  $display("unexpected pixel r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
               reported++;
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue) begin
                  if (reported < 10)
                     $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              want.red, want.green, want.blue, got.red, got.green, got.blue);
                  reported++;
                  fail_count <= fail_count + 1;
               end
            end
         end
         expected_left <= expected_pixels.size();
      end
   end

endmodule

// File: sim/tb_top.sv
module tb_top;

   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 6;
   localparam int HUE_BITS      = 15;
   localparam int HUE_SPAN      = int'(hsvc_pkg::SECTOR_DEG) << HUE_FRAC_BITS;
   localparam int HUE_TURN      = int'(hsvc_pkg::TURN_DEG) << HUE_FRAC_BITS;
   localparam int RANDOM_PIXELS = 400;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 12;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic [HUE_BITS-1:0]     req_hue        = '0;
   logic [CHANNEL_BITS-1:0] req_saturation = '0;
   logic [CHANNEL_BITS-1:0] req_brightness = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic [CHANNEL_BITS-1:0] rsp_red;
   logic [CHANNEL_BITS-1:0] rsp_green;
   logic [CHANNEL_BITS-1:0] rsp_blue;
   int                      fail_count;
   int                      expected_left;
   int                      idle_cycles    = 0;
   int                      sent_pixels    = 0;
   int                      grey_pixels    = 0;
   int                      wrapped_pixels = 0;

   always #1 clock = ~clock;

   hsv_to_rgb_converter #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   hsv_color_checker #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .HUE_BITS      (HUE_BITS)
   ) color_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .fail_count     (fail_count),
      .expected_left  (expected_left)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_pixel(input int hue, input int sat, input int val);
      start          <= 1'b1;
      req_hue        <= HUE_BITS'(hue);
      req_saturation <= CHANNEL_BITS'(sat);
      req_brightness <= CHANNEL_BITS'(val);
      sent_pixels++;
      if (sat == 0)
         grey_pixels++;
      if (hue >= HUE_TURN)
         wrapped_pixels++;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         start          <= 1'b0;
         req_hue        <= HUE_BITS'($urandom);
         req_saturation <= CHANNEL_BITS'($urandom);
         req_brightness <= CHANNEL_BITS'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic drain_pixels();
      start <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
   endtask

   function automatic int pick_hue();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(HUE_TURN, (1 << HUE_BITS) - 1);
         1:       return $urandom_range(0, 6) * HUE_SPAN + $urandom_range(0, 2) - 1 + HUE_TURN;
         default: return $urandom_range(0, HUE_TURN - 1);
      endcase
   endfunction

   function automatic int pick_level();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return (1 << CHANNEL_BITS) - 1;
         2:       return $urandom_range(0, 1) ? 1 : (1 << CHANNEL_BITS) - 2;
         default: return $urandom_range(0, (1 << CHANNEL_BITS) - 1);
      endcase
   endfunction

   initial begin
      int random_sent;
      int burst;
      int hue;
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 6; k++) begin
         send_pixel(k * HUE_SPAN, 255, 255);
         send_pixel(k * HUE_SPAN + HUE_SPAN / 2, 128, 200);
      end
      send_pixel(HUE_SPAN - 1, 255, 255);
      send_pixel(HUE_TURN - 1, 255, 255);
      send_pixel(HUE_TURN, 200, 180);
      send_pixel((1 << HUE_BITS) - 1, 255, 255);
      send_pixel(0, 0, 255);
      send_pixel(12345, 0, 0);
      send_pixel(5000, 255, 0);
      send_pixel(17000, 1, 255);
      send_pixel(9000, 254, 1);
      drain_pixels();

      while (random_sent < RANDOM_PIXELS) begin
         burst = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
         for (int i = 0; i < burst && random_sent < RANDOM_PIXELS; i++) begin
            // wrap near-boundary picks that overflow the hue input width back by one turn
            hue = pick_hue();
            if (hue >= (1 << HUE_BITS))
               hue = hue - HUE_TURN;
            else if (hue >= HUE_TURN + HUE_SPAN * 6 - 1 && hue < (1 << HUE_BITS))
               hue = hue;
            send_pixel(hue, pick_level(), pick_level());
            random_sent++;
         end
         if (random_sent == RANDOM_PIXELS / 2)
            drain_pixels();
         else
            idle_for($urandom_range(0, 8));
      end

      drain_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d pixels (%0d grey, %0d with hue past a full turn),",
               sent_pixels, grey_pixels, wrapped_pixels);
      $display("covering all six hue sectors, their edges and extreme levels in bursts.");
      if (fail_count == 0 && expected_left == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
